>>> rtl/segment_spot_falloff_unit_macros.svh
// assertion macros for the segment spot falloff unit
`ifndef SEGMENT_SPOT_FALLOFF_UNIT_MACROS_SVH
`define SEGMENT_SPOT_FALLOFF_UNIT_MACROS_SVH

// same-cycle implication
`define SSF_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ssf assertion failed");

// next-cycle implication
`define SSF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ssf assertion failed");

`endif

>>> rtl/ssf_pkg.sv
// shared widths, constants and types of the segment spot falloff unit
package ssf_pkg;

  localparam int COORD_BITS = 17;
  localparam int CFG_BITS   = 15;
  localparam int DIFF_BITS  = 18;
  localparam int PROD_BITS  = 36;
  localparam int SUM_BITS   = 37;
  localparam int SQ_BITS    = 35;
  localparam int NUM_BITS   = 70;
  localparam int QUO_BITS   = 35;
  localparam int DIST_BITS  = 18;
  localparam int ROOT_SQ_BITS = 38;
  localparam int AFB        = 16;
  localparam int AMT_BITS   = AFB + 1;

  localparam logic [AMT_BITS-1:0] AMT_FULL = AMT_BITS'(1) << AFB;

  typedef enum logic [1:0] {
    CFG_SPOT_X       = 2'd0,
    CFG_SPOT_Y       = 2'd1,
    CFG_INNER_RADIUS = 2'd2,
    CFG_OUTER_RADIUS = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic full;
    logic zero;
  } ramp_flag_t;

endpackage

>>> rtl/segment_spot_falloff_unit.sv
// top level of the segment spot falloff unit
// Takes one segment request per cycle and returns the floored Q.4 distance
// from the configured spot centre to the nearest point of the segment and a
// Q1.16 falloff amount. The pipeline holds 5 front stages (differences,
// products, sums, case pick with cross square partials, select), 35 restoring
// divider stages for the squared distance, 18 square root stages, 1 radius
// compare stage, 17 ramp divider stages and the output register.
// Throughput is one request per cycle; a stall on the output freezes the
// whole pipeline, so the input stalls only while a result waits unaccepted.
// Spot and radius registers may be written only while no request is in flight.
module segment_spot_falloff_unit (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // config write port
  input  logic                                  cfg_we_i,
  input  logic [1:0]                            cfg_idx_i,
  input  logic [ssf_pkg::CFG_BITS-1:0]          cfg_wdata_i,
  // segment requests
  input  logic                                  valid_i,
  output logic                                  stall_o,
  input  logic signed [ssf_pkg::COORD_BITS-1:0] start_x_i,
  input  logic signed [ssf_pkg::COORD_BITS-1:0] start_y_i,
  input  logic signed [ssf_pkg::COORD_BITS-1:0] end_x_i,
  input  logic signed [ssf_pkg::COORD_BITS-1:0] end_y_i,
  // results
  output logic                                  valid_o,
  input  logic                                  stall_i,
  output logic [ssf_pkg::DIST_BITS-1:0]         distance_o,
  output logic [ssf_pkg::AMT_BITS-1:0]          amount_o
);

  // config registers
  logic [ssf_pkg::CFG_BITS-1:0] spot_x_q, spot_y_q, inner_q, outer_q;

  // global advance: the pipeline moves unless a finished result is held
  logic en;

  logic                          fr_valid;
  logic [ssf_pkg::NUM_BITS-1:0]  fr_num;
  logic [ssf_pkg::SQ_BITS-1:0]   fr_den;
  logic                          qd_valid;
  logic [ssf_pkg::QUO_BITS-1:0]  qd_quo;
  logic                          sq_valid;
  logic [ssf_pkg::DIST_BITS-1:0] sq_root;
  logic                          rp_valid;
  logic [ssf_pkg::DIST_BITS-1:0] rp_dist;
  logic [ssf_pkg::AMT_BITS-1:0]  rp_amount;

  // output register
  logic                          out_valid_q;
  logic [ssf_pkg::DIST_BITS-1:0] dist_q;
  logic [ssf_pkg::AMT_BITS-1:0]  amount_q;

  assign en      = !(out_valid_q && stall_i);
  assign stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spot_x_q <= '0;
      spot_y_q <= '0;
      inner_q  <= '0;
      outer_q  <= '0;
    end else if (cfg_we_i) begin
      case (ssf_pkg::cfg_idx_e'(cfg_idx_i))
        ssf_pkg::CFG_SPOT_X:       spot_x_q <= cfg_wdata_i;
        ssf_pkg::CFG_SPOT_Y:       spot_y_q <= cfg_wdata_i;
        ssf_pkg::CFG_INNER_RADIUS: inner_q  <= cfg_wdata_i;
        ssf_pkg::CFG_OUTER_RADIUS: outer_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // squared distance as numerator over denominator:
  // endpoint cases give |p-a|^2 or |p-b|^2 over 1, interior gives cross^2 over len^2
  ssf_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (valid_i),
    .start_x_i (start_x_i),
    .start_y_i (start_y_i),
    .end_x_i   (end_x_i),
    .end_y_i   (end_y_i),
    .spot_x_i  (spot_x_q),
    .spot_y_i  (spot_y_q),
    .valid_o   (fr_valid),
    .num_o     (fr_num),
    .den_o     (fr_den)
  );

  // floor(sqrt(n/d)) equals floor(sqrt(floor(n/d)))
  ssf_qdiv u_qdiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fr_valid),
    .num_i   (fr_num),
    .den_i   (fr_den),
    .valid_o (qd_valid),
    .quo_o   (qd_quo)
  );

  // root stays below 2^18, so no saturation is needed
  ssf_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (qd_valid),
    .rad_i   (qd_quo),
    .valid_o (sq_valid),
    .root_o  (sq_root)
  );

  // full inside inner, zero beyond outer or for equal radii, ramp between
  ssf_ramp u_ramp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (sq_valid),
    .dist_i   (sq_root),
    .inner_i  (inner_q),
    .outer_i  (outer_q),
    .valid_o  (rp_valid),
    .dist_o   (rp_dist),
    .amount_o (rp_amount)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= rp_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dist_q   <= rp_dist;
      amount_q <= rp_amount;
    end
  end

  assign valid_o    = out_valid_q;
  assign distance_o = dist_q;
  assign amount_o   = amount_q;

endmodule

>>> rtl/ssf_front.sv
// differences, products and case selection ahead of the quotient pipeline
module ssf_front (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   en_i,
  input  logic                                   valid_i,
  input  logic signed [ssf_pkg::COORD_BITS-1:0]  start_x_i,
  input  logic signed [ssf_pkg::COORD_BITS-1:0]  start_y_i,
  input  logic signed [ssf_pkg::COORD_BITS-1:0]  end_x_i,
  input  logic signed [ssf_pkg::COORD_BITS-1:0]  end_y_i,
  input  logic        [ssf_pkg::CFG_BITS-1:0]    spot_x_i,
  input  logic        [ssf_pkg::CFG_BITS-1:0]    spot_y_i,
  output logic                                   valid_o,
  output logic        [ssf_pkg::NUM_BITS-1:0]    num_o,
  output logic        [ssf_pkg::SQ_BITS-1:0]     den_o
);

  // stage 1: differences
  logic v1_q;
  logic signed [ssf_pkg::DIFF_BITS-1:0] sa_q, sb_q, sc_q, sd_q, ea_q, eb_q;
  logic signed [ssf_pkg::DIFF_BITS-1:0] px, py;
  // stage 2: products
  logic v2_q;
  logic signed [ssf_pkg::PROD_BITS-1:0] cc_q, dd_q, ac_q, bd_q, ad_q, bc_q;
  logic signed [ssf_pkg::PROD_BITS-1:0] aa_q, bb_q, ee_q, ff_q;
  // stage 3: sums
  logic v3_q;
  logic        [ssf_pkg::SQ_BITS-1:0]  len_q, pa_q, pb_q;
  logic signed [ssf_pkg::SUM_BITS-1:0] dot_q, cross_q;
  logic signed [ssf_pkg::SUM_BITS-1:0] len_s, pa_s, pb_s;
  // stage 4: case pick and cross square partials
  logic v4_q;
  logic                               pt_q;
  logic [ssf_pkg::SQ_BITS-1:0]        ptsq_q, den4_q;
  logic [35:0]                        hh_q;
  logic [34:0]                        hl_q;
  logic [33:0]                        ll_q;
  logic                               sel_a, sel_b;
  logic signed [ssf_pkg::SUM_BITS-1:0] cneg;
  logic [ssf_pkg::SQ_BITS-1:0]        cabs;
  logic [17:0]                        chi;
  logic [16:0]                        clo;
  // stage 5
  logic                               v5_q;
  logic [ssf_pkg::NUM_BITS-1:0]       num_q;
  logic [ssf_pkg::SQ_BITS-1:0]        den_q;

  assign px = $signed({3'b000, spot_x_i});
  assign py = $signed({3'b000, spot_y_i});

  assign len_s = ssf_pkg::SUM_BITS'(cc_q) + ssf_pkg::SUM_BITS'(dd_q);
  assign pa_s  = ssf_pkg::SUM_BITS'(aa_q) + ssf_pkg::SUM_BITS'(bb_q);
  assign pb_s  = ssf_pkg::SUM_BITS'(ee_q) + ssf_pkg::SUM_BITS'(ff_q);

  // zero length or projection at or before a picks a; at or past b picks b
  assign sel_a = (len_q == '0) || (dot_q <= 0);
  assign sel_b = !sel_a && ($unsigned(dot_q) >= {2'b00, len_q});
  assign cneg  = -cross_q;
  assign cabs  = cross_q[ssf_pkg::SUM_BITS-1] ? cneg[ssf_pkg::SQ_BITS-1:0]
                                               : cross_q[ssf_pkg::SQ_BITS-1:0];
  assign chi   = cabs[34:17];
  assign clo   = cabs[16:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sa_q <= px - ssf_pkg::DIFF_BITS'(start_x_i);
      sb_q <= py - ssf_pkg::DIFF_BITS'(start_y_i);
      sc_q <= ssf_pkg::DIFF_BITS'(end_x_i) - ssf_pkg::DIFF_BITS'(start_x_i);
      sd_q <= ssf_pkg::DIFF_BITS'(end_y_i) - ssf_pkg::DIFF_BITS'(start_y_i);
      ea_q <= px - ssf_pkg::DIFF_BITS'(end_x_i);
      eb_q <= py - ssf_pkg::DIFF_BITS'(end_y_i);

      cc_q <= sc_q * sc_q;
      dd_q <= sd_q * sd_q;
      ac_q <= sa_q * sc_q;
      bd_q <= sb_q * sd_q;
      ad_q <= sa_q * sd_q;
      bc_q <= sb_q * sc_q;
      aa_q <= sa_q * sa_q;
      bb_q <= sb_q * sb_q;
      ee_q <= ea_q * ea_q;
      ff_q <= eb_q * eb_q;

      len_q   <= len_s[ssf_pkg::SQ_BITS-1:0];
      pa_q    <= pa_s[ssf_pkg::SQ_BITS-1:0];
      pb_q    <= pb_s[ssf_pkg::SQ_BITS-1:0];
      dot_q   <= ssf_pkg::SUM_BITS'(ac_q) + ssf_pkg::SUM_BITS'(bd_q);
      cross_q <= ssf_pkg::SUM_BITS'(ad_q) - ssf_pkg::SUM_BITS'(bc_q);

      pt_q   <= sel_a || sel_b;
      ptsq_q <= sel_a ? pa_q : pb_q;
      den4_q <= len_q;
      hh_q   <= chi * chi;
      hl_q   <= chi * clo;
      ll_q   <= clo * clo;

      num_q <= pt_q ? {35'd0, ptsq_q}
                    : ({hh_q, 34'd0} + {17'd0, hl_q, 18'd0} + {36'd0, ll_q});
      den_q <= pt_q ? ssf_pkg::SQ_BITS'(1) : den4_q;
    end
  end

  assign valid_o = v5_q;
  assign num_o   = num_q;
  assign den_o   = den_q;

endmodule

>>> rtl/ssf_qdiv.sv
// restoring divider, one quotient bit per stage
module ssf_qdiv (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                valid_i,
  input  logic [ssf_pkg::NUM_BITS-1:0]        num_i,
  input  logic [ssf_pkg::SQ_BITS-1:0]         den_i,
  output logic                                valid_o,
  output logic [ssf_pkg::QUO_BITS-1:0]        quo_o
);

  logic                           v_q  [ssf_pkg::QUO_BITS];
  logic [ssf_pkg::SQ_BITS-1:0]    r_q  [ssf_pkg::QUO_BITS];
  logic [ssf_pkg::SQ_BITS-1:0]    d_q  [ssf_pkg::QUO_BITS];
  logic [ssf_pkg::QUO_BITS-1:0]   lo_q [ssf_pkg::QUO_BITS];
  logic [ssf_pkg::QUO_BITS-1:0]   q_q  [ssf_pkg::QUO_BITS];

  for (genvar g = 0; g < ssf_pkg::QUO_BITS; g++) begin : g_stage
    logic                          v_in;
    logic [ssf_pkg::SQ_BITS-1:0]   r_in, d_in;
    logic [ssf_pkg::QUO_BITS-1:0]  lo_in, q_in;
    logic [ssf_pkg::SQ_BITS:0]     t, diff;
    logic                          ge;

    if (g == 0) begin : g_first
      // the quotient fits its width, so the top part is already below den
      assign v_in  = valid_i;
      assign r_in  = num_i[ssf_pkg::NUM_BITS-1:ssf_pkg::QUO_BITS];
      assign d_in  = den_i;
      assign lo_in = num_i[ssf_pkg::QUO_BITS-1:0];
      assign q_in  = '0;
    end else begin : g_next
      assign v_in  = v_q[g-1];
      assign r_in  = r_q[g-1];
      assign d_in  = d_q[g-1];
      assign lo_in = lo_q[g-1];
      assign q_in  = q_q[g-1];
    end

    assign t    = {r_in, lo_in[ssf_pkg::QUO_BITS-1]};
    assign diff = t - {1'b0, d_in};
    assign ge   = t >= {1'b0, d_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[g] <= 1'b0;
      end else if (en_i) begin
        v_q[g] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[g]  <= ge ? diff[ssf_pkg::SQ_BITS-1:0] : t[ssf_pkg::SQ_BITS-1:0];
        d_q[g]  <= d_in;
        lo_q[g] <= {lo_in[ssf_pkg::QUO_BITS-2:0], 1'b0};
        q_q[g]  <= {q_in[ssf_pkg::QUO_BITS-2:0], ge};
      end
    end
  end

  assign valid_o = v_q[ssf_pkg::QUO_BITS-1];
  assign quo_o   = q_q[ssf_pkg::QUO_BITS-1];

endmodule

>>> rtl/ssf_isqrt.sv
// integer square root, one root bit per stage
module ssf_isqrt (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  logic [ssf_pkg::QUO_BITS-1:0]      rad_i,
  output logic                              valid_o,
  output logic [ssf_pkg::DIST_BITS-1:0]     root_o
);

  localparam int RW = ssf_pkg::ROOT_SQ_BITS;

  logic                              v_q    [ssf_pkg::DIST_BITS];
  logic [ssf_pkg::QUO_BITS-1:0]      rad_q  [ssf_pkg::DIST_BITS];
  logic [ssf_pkg::DIST_BITS-1:0]     root_q [ssf_pkg::DIST_BITS];
  logic [RW-1:0]                     sq_q   [ssf_pkg::DIST_BITS];

  for (genvar g = 0; g < ssf_pkg::DIST_BITS; g++) begin : g_stage
    localparam int B = ssf_pkg::DIST_BITS - 1 - g;
    logic                           v_in;
    logic [ssf_pkg::QUO_BITS-1:0]   rad_in;
    logic [ssf_pkg::DIST_BITS-1:0]  root_in;
    logic [RW-1:0]                  sq_in, cand;
    logic                           take;

    if (g == 0) begin : g_first
      assign v_in    = valid_i;
      assign rad_in  = rad_i;
      assign root_in = '0;
      assign sq_in   = '0;
    end else begin : g_next
      assign v_in    = v_q[g-1];
      assign rad_in  = rad_q[g-1];
      assign root_in = root_q[g-1];
      assign sq_in   = sq_q[g-1];
    end

    // (root + 2^B)^2 = root^2 + root*2^(B+1) + 2^(2B)
    assign cand = sq_in + (RW'(root_in) << (B + 1)) + (RW'(1) << (2 * B));
    assign take = cand <= RW'(rad_in);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[g] <= 1'b0;
      end else if (en_i) begin
        v_q[g] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[g]  <= rad_in;
        root_q[g] <= take ? (root_in | (ssf_pkg::DIST_BITS'(1) << B)) : root_in;
        sq_q[g]   <= take ? cand : sq_in;
      end
    end
  end

  assign valid_o = v_q[ssf_pkg::DIST_BITS-1];
  assign root_o  = root_q[ssf_pkg::DIST_BITS-1];

endmodule

>>> rtl/ssf_ramp.sv
// radius compare and falloff ramp divider
module ssf_ramp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  logic [ssf_pkg::DIST_BITS-1:0]     dist_i,
  input  logic [ssf_pkg::CFG_BITS-1:0]      inner_i,
  input  logic [ssf_pkg::CFG_BITS-1:0]      outer_i,
  output logic                              valid_o,
  output logic [ssf_pkg::DIST_BITS-1:0]     dist_o,
  output logic [ssf_pkg::AMT_BITS-1:0]      amount_o
);

  localparam int NS = ssf_pkg::AMT_BITS;
  localparam int CW = ssf_pkg::CFG_BITS;

  // compare stage
  logic                          v0_q;
  logic [ssf_pkg::DIST_BITS-1:0] d0_q;
  ssf_pkg::ramp_flag_t           f0_q, f0_d;
  logic [CW-1:0]                 diff0_q, den0_q;

  logic                          v_q    [NS];
  logic [ssf_pkg::DIST_BITS-1:0] dist_q [NS];
  ssf_pkg::ramp_flag_t           f_q    [NS];
  logic [CW-1:0]                 r_q    [NS];
  logic [CW-1:0]                 den_q  [NS];
  logic [NS-1:0]                 lo_q   [NS];
  logic [NS-1:0]                 q_q    [NS];

  always_comb begin
    f0_d.full = dist_i < ssf_pkg::DIST_BITS'(inner_i);
    f0_d.zero = !f0_d.full && ((dist_i > ssf_pkg::DIST_BITS'(outer_i)) ||
                               (outer_i == inner_i));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en_i) begin
      v0_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d0_q    <= dist_i;
      f0_q    <= f0_d;
      diff0_q <= outer_i - dist_i[CW-1:0];
      den0_q  <= outer_i - inner_i;
    end
  end

  for (genvar g = 0; g < NS; g++) begin : g_stage
    logic                          v_in;
    logic [ssf_pkg::DIST_BITS-1:0] dist_in;
    ssf_pkg::ramp_flag_t           f_in;
    logic [CW-1:0]                 r_in, den_in;
    logic [NS-1:0]                 lo_in, q_in;
    logic [CW:0]                   t, sub;
    logic                          ge;

    if (g == 0) begin : g_first
      // numerator is diff shifted up by the fraction bits
      assign v_in    = v0_q;
      assign dist_in = d0_q;
      assign f_in    = f0_q;
      assign r_in    = diff0_q >> 1;
      assign den_in  = den0_q;
      assign lo_in   = {diff0_q[0], {(NS-1){1'b0}}};
      assign q_in    = '0;
    end else begin : g_next
      assign v_in    = v_q[g-1];
      assign dist_in = dist_q[g-1];
      assign f_in    = f_q[g-1];
      assign r_in    = r_q[g-1];
      assign den_in  = den_q[g-1];
      assign lo_in   = lo_q[g-1];
      assign q_in    = q_q[g-1];
    end

    assign t   = {r_in, lo_in[NS-1]};
    assign sub = t - {1'b0, den_in};
    assign ge  = t >= {1'b0, den_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[g] <= 1'b0;
      end else if (en_i) begin
        v_q[g] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dist_q[g] <= dist_in;
        f_q[g]    <= f_in;
        r_q[g]    <= ge ? sub[CW-1:0] : t[CW-1:0];
        den_q[g]  <= den_in;
        lo_q[g]   <= {lo_in[NS-2:0], 1'b0};
        q_q[g]    <= {q_in[NS-2:0], ge};
      end
    end
  end

  assign valid_o  = v_q[NS-1];
  assign dist_o   = dist_q[NS-1];
  assign amount_o = f_q[NS-1].full ? ssf_pkg::AMT_FULL :
                    f_q[NS-1].zero ? '0 : q_q[NS-1];

endmodule

>>> rtl/ssf_checker.sv
// port-level checks of the segment spot falloff unit and their binding
`include "segment_spot_falloff_unit_macros.svh"

module ssf_checker (
  input logic                                  clk_i,
  input logic                                  rst_ni,
  input logic                                  valid_i,
  input logic                                  stall_o,
  input logic                                  valid_o,
  input logic                                  stall_i,
  input logic [ssf_pkg::DIST_BITS-1:0]         distance_o,
  input logic [ssf_pkg::AMT_BITS-1:0]          amount_o
);

  // input stalls only while a result is held at the output
  `SSF_ASSERT_IMPLY(a_stall_cause, clk_i, rst_ni, stall_o, valid_o && stall_i)

  // a request is taken at once while the output holds nothing
  `SSF_ASSERT_IMPLY(a_req_taken, clk_i, rst_ni, valid_i && !valid_o, !stall_o)

  // amount never exceeds full
  `SSF_ASSERT_IMPLY(a_amount_max, clk_i, rst_ni, valid_o, amount_o <= ssf_pkg::AMT_FULL)

  // a held result stays put
  `SSF_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, valid_o && stall_i, valid_o && $stable(distance_o) && $stable(amount_o))

endmodule

bind segment_spot_falloff_unit ssf_checker u_ssf_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .valid_i    (valid_i),
  .stall_o    (stall_o),
  .valid_o    (valid_o),
  .stall_i    (stall_i),
  .distance_o (distance_o),
  .amount_o   (amount_o)
);
